### src/smbios_battery_record_extractor_top_defines.svh
// Assertion helpers used by the parser.
`ifndef SMBIOS_BATTERY_RECORD_EXTRACTOR_TOP_DEFINES_SVH
`define SMBIOS_BATTERY_RECORD_EXTRACTOR_TOP_DEFINES_SVH

// Consequent checked in the same cycle.
`define SBRE_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SBRE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/sbre_pkg.sv
package sbre_pkg;

   localparam int STRING_CAPACITY_DEF = 32;
   localparam int TABLE_LEN_W = 32;

   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] table_byte;
      logic       table_start;
   } req_item_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  string_char;
      logic [2:0]  string_mask;
      logic        battery_found;
      logic [23:0] design_energy;
      logic [15:0] voltage_mv;
      logic [2:0]  chemistry_code;
   } rsp_item_type;

   // Chemistry 3..8 maps to 1..6, anything else is unknown.
   function automatic logic [2:0] renumber_chemistry(input logic [7:0] v);
      logic [7:0] d;
      d = v - 8'd2;
      if (v inside {[8'd3:8'd8]}) begin
         return d[2:0];
      end
      return 3'd0;
   endfunction

endpackage

### src/sbre_req_if.sv
interface sbre_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] table_byte;
   logic       table_start;

   modport source (output valid, output table_byte, output table_start, input ready);
   modport sink   (input valid, input table_byte, input table_start, output ready);
endinterface

### src/sbre_rsp_if.sv
interface sbre_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  string_char;
   logic [2:0]  string_mask;
   logic        battery_found;
   logic [23:0] design_energy;
   logic [15:0] voltage_mv;
   logic [2:0]  chemistry_code;

   modport source (output valid, output result_kind, output string_char, output string_mask,
                   output battery_found, output design_energy, output voltage_mv,
                   output chemistry_code, input ready);
   modport sink   (input valid, input result_kind, input string_char, input string_mask,
                   input battery_found, input design_energy, input voltage_mv,
                   input chemistry_code, output ready);
endinterface

### src/sbre_in_stage.sv
module sbre_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   sbre_req_if.sink              req_ch,
   input  logic                  pop,
   output logic                  item_valid,
   output sbre_pkg::req_item_type item
);

   logic                   valid_ff;
   logic                   valid_in;
   sbre_pkg::req_item_type item_ff;
   logic                   take;

   assign req_ch.ready = !valid_ff || pop;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.table_byte  <= req_ch.table_byte;
         item_ff.table_start <= req_ch.table_start;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

### src/sbre_parser.sv
`include "smbios_battery_record_extractor_top_defines.svh"

module sbre_parser #(
   parameter int STRING_CAPACITY = sbre_pkg::STRING_CAPACITY_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  sbre_pkg::req_item_type              item,
   input  logic [sbre_pkg::TABLE_LEN_W-1:0]    tbl_size,
   output logic                                res_valid,
   output sbre_pkg::rsp_item_type              res
);

   localparam int CW = $clog2(STRING_CAPACITY);
   localparam logic [CW-1:0] CHARS_MAX = CW'(STRING_CAPACITY - 1);
   localparam int LW = sbre_pkg::TABLE_LEN_W;

   localparam logic [2:0] PH_TYPE    = 3'd0;
   localparam logic [2:0] PH_LENGTH  = 3'd1;
   localparam logic [2:0] PH_FIXED   = 3'd2;
   localparam logic [2:0] PH_STRINGS = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;

   localparam logic [7:0] BATTERY_TYPE    = 8'd22;
   localparam logic [7:0] MIN_REC_LEN     = 8'd4;
   localparam logic [7:0] SUMMARY_MIN_LEN = 8'd14;
   localparam logic [7:0] MULT_MIN_LEN    = 8'd21;

   localparam logic [LW-1:0] REL_LOCATION = LW'(4);
   localparam logic [LW-1:0] REL_MAKER    = LW'(5);
   localparam logic [LW-1:0] REL_NAME     = LW'(8);
   localparam logic [LW-1:0] REL_CHEM     = LW'(9);
   localparam logic [LW-1:0] REL_CAP_LO   = LW'(10);
   localparam logic [LW-1:0] REL_CAP_HI   = LW'(11);
   localparam logic [LW-1:0] REL_VOLT_LO  = LW'(12);
   localparam logic [LW-1:0] REL_VOLT_HI  = LW'(13);
   localparam logic [LW-1:0] REL_MULT     = LW'(21);

   logic [LW-1:0] off_ff, off_in, cur_off;
   logic [LW-1:0] rs_ff, rs_in, cur_rs;
   logic [7:0]    len_ff, len_in, cur_len;
   logic [2:0]    phase_ff, phase_in, cur_phase;
   logic          bat_ff, bat_in, cur_bat;
   logic          pnul_ff, pnul_in, cur_pnul;
   logic [7:0]    snum_ff, snum_in, cur_snum;
   logic [CW-1:0] chars_ff, chars_in, cur_chars;
   logic [7:0]    want_ff [3];
   logic [7:0]    want_in [3];
   logic [7:0]    cur_want [3];
   logic [15:0]   cap_ff, cap_in, cur_cap;
   logic [15:0]   volt_ff, volt_in, cur_volt;
   logic [7:0]    chem_ff, chem_in, cur_chem;
   logic [7:0]    mult_ff, mult_in, cur_mult;
   logic          done_ff, done_in, cur_done;

   logic [LW-1:0] rel;
   logic          past_end, last, type_short, next_short, fixed_end;
   logic [2:0]    hit;
   logic          fin, emit;
   logic [7:0]    mult_sel;
   logic [23:0]   energy;
   logic          has_summary;
   logic [7:0]    b;

   assign b = item.table_byte;

   always_comb begin
      cur_off   = item.table_start ? '0 : off_ff;
      cur_rs    = item.table_start ? '0 : rs_ff;
      cur_len   = item.table_start ? '0 : len_ff;
      cur_phase = item.table_start ? PH_TYPE : phase_ff;
      cur_bat   = item.table_start ? 1'b0 : bat_ff;
      cur_pnul  = item.table_start ? 1'b0 : pnul_ff;
      cur_snum  = item.table_start ? 8'd1 : snum_ff;
      cur_chars = item.table_start ? '0 : chars_ff;
      cur_cap   = item.table_start ? '0 : cap_ff;
      cur_volt  = item.table_start ? '0 : volt_ff;
      cur_chem  = item.table_start ? '0 : chem_ff;
      cur_mult  = item.table_start ? '0 : mult_ff;
      cur_done  = item.table_start ? 1'b0 : done_ff;
      for (int j = 0; j < 3; j++) begin
         cur_want[j] = item.table_start ? 8'd0 : want_ff[j];
      end
   end

   assign rel        = cur_off - cur_rs;
   assign past_end   = cur_off >= tbl_size;
   assign last       = ({1'b0, cur_off} + (LW+1)'(1)) >= {1'b0, tbl_size};
   assign type_short = ({1'b0, cur_rs} + (LW+1)'(4)) > {1'b0, tbl_size};
   assign next_short = ({1'b0, cur_off} + (LW+1)'(5)) > {1'b0, tbl_size};
   assign fixed_end  = ({1'b0, rel} + (LW+1)'(1)) >= (LW+1)'(cur_len);

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         hit[j] = (cur_want[j] != 8'd0) && (cur_want[j] == cur_snum);
      end
   end

   always_comb begin
      off_in   = cur_off;
      rs_in    = cur_rs;
      len_in   = cur_len;
      phase_in = cur_phase;
      bat_in   = cur_bat;
      pnul_in  = cur_pnul;
      snum_in  = cur_snum;
      chars_in = cur_chars;
      cap_in   = cur_cap;
      volt_in  = cur_volt;
      chem_in  = cur_chem;
      mult_in  = cur_mult;
      done_in  = cur_done;
      for (int j = 0; j < 3; j++) begin
         want_in[j] = cur_want[j];
      end
      fin  = 1'b0;
      emit = 1'b0;

      if (!cur_done) begin
         if (past_end) begin
            fin = 1'b1;
         end else begin
            case (cur_phase)
               PH_TYPE: begin
                  if (type_short) begin
                     fin = 1'b1;
                  end else begin
                     bat_in   = (b == BATTERY_TYPE);
                     phase_in = PH_LENGTH;
                  end
               end
               PH_LENGTH: begin
                  len_in = b;
                  if (b < MIN_REC_LEN) begin
                     fin = 1'b1;
                  end else begin
                     phase_in = PH_FIXED;
                  end
               end
               PH_FIXED: begin
                  if (cur_bat) begin
                     case (rel)
                        REL_LOCATION: want_in[0] = b;
                        REL_MAKER:    want_in[1] = b;
                        REL_NAME:     want_in[2] = b;
                        REL_CHEM:     chem_in = b;
                        REL_CAP_LO:   cap_in = {cur_cap[15:8], b};
                        REL_CAP_HI:   cap_in = {b, cur_cap[7:0]};
                        REL_VOLT_LO:  volt_in = {cur_volt[15:8], b};
                        REL_VOLT_HI:  volt_in = {b, cur_volt[7:0]};
                        REL_MULT:     mult_in = b;
                        default: ;
                     endcase
                  end
                  if (fixed_end) begin
                     phase_in = PH_STRINGS;
                     snum_in  = 8'd1;
                     chars_in = '0;
                     pnul_in  = cur_bat;
                  end
               end
               PH_STRINGS: begin
                  if (b == 8'd0) begin
                     if (cur_pnul) begin
                        if (cur_bat || next_short) begin
                           fin = 1'b1;
                        end else begin
                           rs_in    = cur_off + LW'(1);
                           phase_in = PH_TYPE;
                           bat_in   = 1'b0;
                        end
                     end else begin
                        pnul_in  = 1'b1;
                        chars_in = '0;
                        if (cur_snum != 8'd0) begin
                           snum_in = cur_snum + 8'd1;
                        end
                     end
                  end else begin
                     pnul_in = 1'b0;
                     if (cur_bat && (cur_chars < CHARS_MAX)) begin
                        chars_in = cur_chars + CW'(1);
                        emit     = (hit != 3'd0);
                     end
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
            if (!fin) begin
               off_in = cur_off + LW'(1);
               if (last) begin
                  fin = 1'b1;
               end
            end
         end
      end

      if (fin) begin
         done_in  = 1'b1;
         phase_in = PH_DONE;
      end
   end

   // Summary built from the post-update record fields.
   always_comb begin
      has_summary = bat_in && (len_in >= SUMMARY_MIN_LEN);
      mult_sel    = ((len_in > MULT_MIN_LEN) && (mult_in > 8'd1)) ? mult_in : 8'd1;
      energy      = {8'd0, cap_in} * {16'd0, mult_sel};

      res = '0;
      if (fin) begin
         res.result_kind   = sbre_pkg::KIND_SUMMARY;
         res.battery_found = bat_in;
         if (has_summary) begin
            res.design_energy  = energy;
            res.voltage_mv     = volt_in;
            res.chemistry_code = sbre_pkg::renumber_chemistry(chem_in);
         end
      end else begin
         res.result_kind = sbre_pkg::KIND_CHAR;
         res.string_char = b;
         res.string_mask = hit;
      end
      res_valid = fin || emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff   <= '0;
         rs_ff    <= '0;
         len_ff   <= '0;
         phase_ff <= PH_TYPE;
         bat_ff   <= 1'b0;
         pnul_ff  <= 1'b0;
         snum_ff  <= 8'd1;
         chars_ff <= '0;
         cap_ff   <= '0;
         volt_ff  <= '0;
         chem_ff  <= '0;
         mult_ff  <= '0;
         done_ff  <= 1'b0;
         for (int j = 0; j < 3; j++) begin
            want_ff[j] <= '0;
         end
      end else if (step) begin
         off_ff   <= off_in;
         rs_ff    <= rs_in;
         len_ff   <= len_in;
         phase_ff <= phase_in;
         bat_ff   <= bat_in;
         pnul_ff  <= pnul_in;
         snum_ff  <= snum_in;
         chars_ff <= chars_in;
         cap_ff   <= cap_in;
         volt_ff  <= volt_in;
         chem_ff  <= chem_in;
         mult_ff  <= mult_in;
         done_ff  <= done_in;
         for (int j = 0; j < 3; j++) begin
            want_ff[j] <= want_in[j];
         end
      end
   end

   `SBRE_ASSERT_SAME(a_done_silent, clock, reset, step && done_ff && !item.table_start, !res_valid, "byte after parse end produced a result")
   `SBRE_ASSERT_NEXT(a_summary_ends, clock, reset, step && res_valid && (res.result_kind == sbre_pkg::KIND_SUMMARY), done_ff && (phase_ff == PH_DONE), "summary without parse end")
   `SBRE_ASSERT_SAME(a_char_masked, clock, reset, step && res_valid && (res.result_kind == sbre_pkg::KIND_CHAR), (res.string_mask != 3'd0) && bat_in && (cur_phase == PH_STRINGS), "character outside a selected battery string")
   `SBRE_ASSERT_SAME(a_done_phase, clock, reset, done_ff, phase_ff == PH_DONE, "done flag and phase disagree")

endmodule

### src/sbre_out_stage.sv
module sbre_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sbre_pkg::rsp_item_type item,
   output logic                   can_take,
   sbre_rsp_if.source             rsp_ch
);

   logic                   valid_ff;
   logic                   valid_in;
   sbre_pkg::rsp_item_type item_ff;

   assign can_take = !valid_ff || rsp_ch.ready;
   assign valid_in = can_take ? push : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_take && push) begin
         item_ff <= item;
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.result_kind    = item_ff.result_kind;
   assign rsp_ch.string_char    = item_ff.string_char;
   assign rsp_ch.string_mask    = item_ff.string_mask;
   assign rsp_ch.battery_found  = item_ff.battery_found;
   assign rsp_ch.design_energy  = item_ff.design_energy;
   assign rsp_ch.voltage_mv     = item_ff.voltage_mv;
   assign rsp_ch.chemistry_code = item_ff.chemistry_code;

endmodule

### src/smbios_battery_record_extractor_top.sv
// Battery record extractor for an SMBIOS structure table.
// req_ch takes one table byte per transfer, in address order; table_start
// marks the first byte of a table and restarts the parse. rsp_ch carries
// string characters of the first type-22 record (location, maker, name,
// each up to STRING_CAPACITY-1 characters, tagged by a mask) and one final
// summary per parse. csr_wr_en/csr_wr_data load the table length; write it
// only while no transfer is in flight.
// A byte is held in the input register after its transfer, passes the
// combinational parser into the result register and then transfers on
// rsp_ch. Throughput: one byte per cycle while rsp_ch does not stall; the
// parse state update is a single combinational step between the input and
// result registers. A stalled rsp_ch holds its result and the parser; the
// input register takes one more byte only if it is empty, after which
// req_ch.ready stays low until the result is taken. Bytes that yield no
// result wait as well, so a stall delays the whole byte stream.
// Reset (synchronous, active high) empties both registers, clears the
// parse state and sets the table length to zero.
module smbios_battery_record_extractor_top #(
   parameter int STRING_CAPACITY = sbre_pkg::STRING_CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   sbre_req_if.sink                         req_ch,
   sbre_rsp_if.source                       rsp_ch,
   input  logic                             csr_wr_en,
   input  logic [sbre_pkg::TABLE_LEN_W-1:0] csr_wr_data
);

   logic [sbre_pkg::TABLE_LEN_W-1:0] tbl_size_ff;
   logic                             item_valid;
   sbre_pkg::req_item_type           item;
   logic                             can_take;
   logic                             step;
   logic                             res_valid;
   sbre_pkg::rsp_item_type           res;

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_size_ff <= '0;
      end else if (csr_wr_en) begin
         tbl_size_ff <= csr_wr_data;
      end
   end

   assign step = item_valid && can_take;

   sbre_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .pop        (step),
      .item_valid (item_valid),
      .item       (item)
   );

   sbre_parser #(
      .STRING_CAPACITY (STRING_CAPACITY)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .item         (item),
      .tbl_size     (tbl_size_ff),
      .res_valid    (res_valid),
      .res          (res)
   );

   sbre_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .push     (step && res_valid),
      .item     (res),
      .can_take (can_take),
      .rsp_ch   (rsp_ch)
   );

endmodule

### tb/tb_top.sv
module tb_top;

   localparam logic [7:0]  BATTERY_TYPE = 8'd22;
   localparam logic [31:0] OFS_LOC      = 32'd4;
   localparam logic [31:0] OFS_MAKER    = 32'd5;
   localparam logic [31:0] OFS_NAME     = 32'd8;
   localparam logic [31:0] OFS_CHEM     = 32'd9;
   localparam logic [31:0] OFS_CAP_LO   = 32'd10;
   localparam logic [31:0] OFS_CAP_HI   = 32'd11;
   localparam logic [31:0] OFS_VOLT_LO  = 32'd12;
   localparam logic [31:0] OFS_VOLT_HI  = 32'd13;
   localparam logic [31:0] OFS_MULT     = 32'd21;
   localparam int unsigned STR_KEEP     = sbre_pkg::STRING_CAPACITY_DEF - 1;
   localparam int unsigned RAND_ITEMS   = 1750;
   localparam int unsigned SETTLE       = 8;

   localparam logic [2:0] WALK_TYPE      = 3'd0;
   localparam logic [2:0] WALK_LENGTH    = 3'd1;
   localparam logic [2:0] WALK_FORMATTED = 3'd2;
   localparam logic [2:0] WALK_STRINGS   = 3'd3;
   localparam logic [2:0] WALK_DONE      = 3'd4;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [sbre_pkg::TABLE_LEN_W-1:0] csr_wr_data;

   sbre_req_if req_bus();
   sbre_rsp_if rsp_bus();

   smbios_battery_record_extractor_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [31:0] tbl_len;
   logic [31:0] pos;
   logic [31:0] rec_base;
   logic [7:0]  rec_len;
   logic [2:0]  phase;
   logic        in_battery;
   logic        last_nul;
   logic [7:0]  str_idx;
   int unsigned str_chars;
   logic [7:0]  want_idx [3];
   logic [15:0] cap;
   logic [15:0] mv;
   logic [7:0]  chem_raw;
   logic [7:0]  mult_raw;
   logic        finished;

   sbre_pkg::rsp_item_type expected_results [$];
   logic [7:0]   table_bytes [$];

   bit req_idle = 1'b1;
   bit rsp_idle = 1'b1;
   int unsigned n_bytes;
   int unsigned n_checked;
   int unsigned n_fail;
   int unsigned n_settings;

   function automatic void clear_walk();
      pos        = '0;
      rec_base   = '0;
      rec_len    = '0;
      phase      = WALK_TYPE;
      in_battery = 1'b0;
      last_nul   = 1'b0;
      str_idx    = 8'd1;
      str_chars  = 0;
      for (int j = 0; j < 3; j++) want_idx[j] = '0;
      cap        = '0;
      mv         = '0;
      chem_raw   = '0;
      mult_raw   = '0;
      finished   = 1'b0;
   endfunction

   function automatic sbre_pkg::rsp_item_type close_parse();
      sbre_pkg::rsp_item_type r;
      logic [7:0] m;
      logic [7:0] c;
      finished = 1'b1;
      phase = WALK_DONE;
      r = '0;
      r.result_kind = sbre_pkg::KIND_SUMMARY;
      r.battery_found = in_battery;
      if (in_battery && rec_len >= 8'd14) begin
         m = (rec_len > 8'd21 && mult_raw > 8'd1) ? mult_raw : 8'd1;
         r.design_energy = {8'd0, cap} * {16'd0, m};
         r.voltage_mv = mv;
         c = (chem_raw >= 8'd3 && chem_raw <= 8'd8) ? chem_raw - 8'd2 : 8'd0;
         r.chemistry_code = c[2:0];
      end
      return r;
   endfunction

   function automatic void parse_byte(input logic [7:0] b, input logic s);
      logic [32:0] len;
      logic [32:0] off;
      logic [32:0] nxt;
      logic [31:0] rel;
      logic [2:0]  mask;
      bit          emit;
      bit          last;
      sbre_pkg::rsp_item_type r;
      if (s) clear_walk();
      if (finished) return;
      len = {1'b0, tbl_len};
      off = {1'b0, pos};
      if (off >= len) begin
         expected_results.push_back(close_parse());
         return;
      end
      rel  = pos - rec_base;
      last = (off + 33'd1 >= len);
      emit = 1'b0;
      mask = '0;
      case (phase)
         WALK_TYPE: begin
            if ({1'b0, rec_base} + 33'd4 > len) begin
               expected_results.push_back(close_parse());
               return;
            end
            in_battery = (b == BATTERY_TYPE);
            phase = WALK_LENGTH;
         end
         WALK_LENGTH: begin
            rec_len = b;
            if (b < 8'd4) begin
               expected_results.push_back(close_parse());
               return;
            end
            phase = WALK_FORMATTED;
         end
         WALK_FORMATTED: begin
            if (in_battery) begin
               case (rel)
                  OFS_LOC:     want_idx[0] = b;
                  OFS_MAKER:   want_idx[1] = b;
                  OFS_NAME:    want_idx[2] = b;
                  OFS_CHEM:    chem_raw = b;
                  OFS_CAP_LO:  cap[7:0] = b;
                  OFS_CAP_HI:  cap[15:8] = b;
                  OFS_VOLT_LO: mv[7:0] = b;
                  OFS_VOLT_HI: mv[15:8] = b;
                  OFS_MULT:    mult_raw = b;
                  default: ;
               endcase
            end
            if (rel + 32'd1 >= {24'd0, rec_len}) begin
               phase     = WALK_STRINGS;
               str_idx   = 8'd1;
               str_chars = 0;
               last_nul  = in_battery;
            end
         end
         default: begin
            if (b == 8'd0) begin
               if (last_nul) begin
                  nxt = off + 33'd1;
                  if (in_battery || nxt + 33'd4 > len) begin
                     expected_results.push_back(close_parse());
                     return;
                  end
                  rec_base   = nxt[31:0];
                  phase      = WALK_TYPE;
                  in_battery = 1'b0;
               end else begin
                  last_nul = 1'b1;
                  if (str_idx != 8'd0) str_idx = str_idx + 8'd1;
                  str_chars = 0;
               end
            end else begin
               last_nul = 1'b0;
               if (in_battery) begin
                  for (int j = 0; j < 3; j++)
                     if (want_idx[j] != 8'd0 && want_idx[j] == str_idx) mask[j] = 1'b1;
                  if (str_chars < STR_KEEP) begin
                     str_chars++;
                     emit = (mask != 3'd0);
                  end
               end
            end
         end
      endcase
      pos = pos + 32'd1;
      if (last) begin
         expected_results.push_back(close_parse());
         return;
      end
      if (!emit) return;
      r = '0;
      r.result_kind = sbre_pkg::KIND_CHAR;
      r.string_char = b;
      r.string_mask = mask;
      expected_results.push_back(r);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic s);
      int gap;
      gap = req_idle ? $urandom_range(0, 8) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid       <= 1'b1;
      req_bus.table_byte  <= b;
      req_bus.table_start <= s;
      do @(posedge clock); while (!req_bus.ready);
      parse_byte(b, s);
      n_bytes++;
   endtask

   task automatic send_table(input bit noisy);
      foreach (table_bytes[i])
         send_byte(table_bytes[i], (i == 0) || (noisy && $urandom_range(0, 299) == 0));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_table_length(input logic [31:0] v);
      wait_idle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      tbl_len = v;
      n_settings++;
   endtask

   task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, e, a);
         n_fail++;
      end
   endtask

   // result sink: random stalls, compare each transfer with the oldest expectation
   initial begin
      int gap;
      sbre_pkg::rsp_item_type w;
      gap = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (expected_results.size() == 0) begin
               $error("result with nothing expected: kind %0d char 0x%0h",
                      rsp_bus.result_kind, rsp_bus.string_char);
               n_fail++;
            end else begin
               w = expected_results.pop_front();
               check_field("result_kind", 32'(w.result_kind), 32'(rsp_bus.result_kind));
               check_field("string_char", 32'(w.string_char), 32'(rsp_bus.string_char));
               check_field("string_mask", 32'(w.string_mask), 32'(rsp_bus.string_mask));
               check_field("battery_found", 32'(w.battery_found),
                           32'(rsp_bus.battery_found));
               check_field("design_energy", 32'(w.design_energy),
                           32'(rsp_bus.design_energy));
               check_field("voltage_mv", 32'(w.voltage_mv), 32'(rsp_bus.voltage_mv));
               check_field("chemistry_code", 32'(w.chemistry_code),
                           32'(rsp_bus.chemistry_code));
               n_checked++;
            end
            gap = rsp_idle ? $urandom_range(0, 8) : 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void add_plain_record();
      int unsigned flen;
      int unsigned nstr;
      int unsigned slen;
      logic [7:0]  t;
      t = 8'($urandom_range(0, 255));
      if (t == BATTERY_TYPE) t = t + 8'd1;
      flen = ($urandom_range(0, 15) == 0) ? $urandom_range(4, 255) : $urandom_range(4, 20);
      table_bytes.push_back(t);
      table_bytes.push_back(flen[7:0]);
      repeat (flen - 2) table_bytes.push_back(8'($urandom_range(0, 255)));
      nstr = $urandom_range(0, 3);
      repeat (nstr) begin
         slen = $urandom_range(1, 8);
         repeat (slen) table_bytes.push_back(8'($urandom_range(1, 255)));
         table_bytes.push_back(8'd0);
      end
      if (nstr == 0) table_bytes.push_back(8'd0);
      table_bytes.push_back(8'd0);
   endfunction

   // many: a long string set that runs the string counter past 255
   function automatic void add_battery_record(input bit many);
      int unsigned flen;
      int unsigned nstr;
      int unsigned slen;
      int unsigned rel;
      logic [7:0]  f;
      nstr = many ? 260 : $urandom_range(0, 5);
      case ($urandom_range(0, 3))
         0:       flen = $urandom_range(4, 13);
         1:       flen = $urandom_range(14, 21);
         default: flen = $urandom_range(22, 30);
      endcase
      table_bytes.push_back(BATTERY_TYPE);
      table_bytes.push_back(flen[7:0]);
      for (rel = 2; rel < flen; rel++) begin
         f = 8'($urandom_range(0, 255));
         if (rel == OFS_LOC || rel == OFS_MAKER || rel == OFS_NAME)
            f = many ? (($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom_range(250, 255)))
                     : 8'($urandom_range(0, nstr + 1));
         if (rel == OFS_CHEM && $urandom_range(0, 3) != 0) f = 8'($urandom_range(0, 10));
         table_bytes.push_back(f);
      end
      repeat (nstr) begin
         slen = many ? 1 : (($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40));
         repeat (slen) table_bytes.push_back(8'($urandom_range(1, 255)));
         table_bytes.push_back(8'd0);
      end
      table_bytes.push_back(8'd0);
   endfunction

   task automatic test_empty_and_tiny_tables();
      set_table_length(32'd0);
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b0);
      set_table_length(32'd3);
      send_byte(BATTERY_TYPE, 1'b1);
      send_byte(8'h5A, 1'b0);
   endtask

   task automatic test_battery_fields();
      set_table_length(32'hFFFF_FFFF);
      table_bytes = {BATTERY_TYPE, 8'd22, 8'h00, 8'h00, 8'd1, 8'd2, 8'hAA, 8'h55,
                     8'd1, 8'd8, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66, 8'h77, 8'hFF,
                     8'hFF, 8'h00, 8'h01, 8'h00, 8'h00};
      send_table(1'b0);
   endtask

   task automatic test_short_formatted_length();
      set_table_length(32'hFFFF_FFFF);
      send_byte(BATTERY_TYPE, 1'b1);
      send_byte(8'd3, 1'b0);
      send_byte(8'h05, 1'b1);
      send_byte(8'd2, 1'b0);
   endtask

   task automatic test_table_end_drops_char();
      set_table_length(32'd7);
      table_bytes = {BATTERY_TYPE, 8'd5, 8'h00, 8'h00, 8'd1, 8'h51, 8'h52};
      send_table(1'b0);
   endtask

   task automatic test_lowered_length();
      set_table_length(32'd100);
      table_bytes = {8'h10, 8'h08, 8'h01, 8'h02, 8'h03};
      send_table(1'b0);
      set_table_length(32'd3);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   task automatic test_random_tables();
      int unsigned n_tables;
      int unsigned start_bytes;
      int unsigned sz;
      logic [31:0] len;
      n_tables = 0;
      start_bytes = n_bytes;
      while (n_bytes - start_bytes < RAND_ITEMS) begin
         table_bytes.delete();
         repeat ($urandom_range(0, 4)) add_plain_record();
         if ($urandom_range(0, 4) != 0)
            add_battery_record((n_tables == 0) || ($urandom_range(0, 11) == 0));
         repeat ($urandom_range(0, 2)) add_plain_record();
         if ($urandom_range(0, 7) == 0)
            table_bytes[$urandom_range(0, table_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         sz = table_bytes.size();
         case ($urandom_range(0, 6))
            0:       len = sz;
            1:       len = sz - $urandom_range(1, sz);
            2:       len = sz + $urandom_range(1, 40);
            3:       len = 32'hFFFF_FFFF;
            4:       len = $urandom_range(0, 8);
            5:       len = $urandom();
            default: len = 32'hFFFF_FFFF - $urandom_range(0, 3);
         endcase
         set_table_length(len);
         req_idle = ($urandom_range(0, 3) != 0);
         rsp_idle = ($urandom_range(0, 3) != 0);
         send_table(1'b1);
         repeat ($urandom_range(0, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0);
         n_tables++;
      end
   endtask

   initial begin
      reset               = 1'b1;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      req_bus.valid       = 1'b0;
      req_bus.table_byte  = '0;
      req_bus.table_start = 1'b0;
      tbl_len             = '0;
      clear_walk();
      n_bytes = 0;
      n_checked = 0;
      n_fail = 0;
      n_settings = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_and_tiny_tables();
      test_battery_fields();
      test_short_formatted_length();
      test_table_end_drops_char();
      test_lowered_length();
      test_random_tables();
      wait_idle();

      $display("Sent %0d table bytes under %0d table length settings", n_bytes, n_settings);
      $display("Checked %0d results, %0d mismatches", n_checked, n_fail);
      if (n_fail == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

### files.f
+incdir+src
src/sbre_pkg.sv
src/sbre_req_if.sv
src/sbre_rsp_if.sv
src/sbre_in_stage.sv
src/sbre_parser.sv
src/sbre_out_stage.sv
src/smbios_battery_record_extractor_top.sv
tb/tb_top.sv
